### rtl/mau_pkg.sv
package mau_pkg;

  localparam int unsigned ResW = 31;
  localparam int unsigned RawW = 64;
  localparam int unsigned ExpW = 63;
  localparam logic [ResW-1:0] DefaultModulus = 31'd1000000007;

  typedef enum logic [2:0] {
    CMD_REDUCE   = 3'd0,
    CMD_NEGATE   = 3'd1,
    CMD_ADD      = 3'd2,
    CMD_SUBTRACT = 3'd3,
    CMD_MULTIPLY = 3'd4,
    CMD_POWER    = 3'd5,
    CMD_INVERSE  = 3'd6,
    CMD_DIVIDE   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_NEXT,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_RED,
    PH_MUL,
    PH_SQ,
    PH_BM
  } phase_e;

  typedef struct packed {
    logic [2:0]             command;
    logic signed [RawW-1:0] raw_value;
    logic [ResW-1:0]        operand_a;
    logic [ResW-1:0]        operand_b;
    logic [ExpW-1:0]        exponent;
  } in_t;

  typedef struct packed {
    logic [ResW-1:0] result;
    logic            range_error;
  } out_t;

endpackage

### rtl/modular_arithmetic_unit_top.sv
// Modular arithmetic unit: reduce, negate, add, subtract, multiply, power,
// inverse and divide over the modulus held in the configuration register.
// Request channel: in_valid_i / in_stall_o / in_data_i; a request is taken
// when valid is high and stall is low. Result channel: out_valid_o /
// out_stall_i / out_data_o, one result per request, in order.
// Configuration: cfg_valid_i / cfg_ready_o / cfg_data_i write the modulus;
// ready is high while no request is in progress and none is offered.
// Negate, add, subtract and range errors are settled when the request is
// taken. Multiply (over operand a) and reduce (over the 64-bit magnitude)
// run the bit-serial modular multiplier that handles one multiplier bit per cycle. Power,
// inverse and divide run 63 square steps and one multiply per set exponent
// bit; divide ends with one more multiply by operand a.
// One request is in progress at a time; in_stall_o is high until its result
// sits in the output register. A stalled result holds the output register,
// and a following result waits inside the unit until it frees.
// Reset sets the modulus to 1000000007 and empties the unit.
module modular_arithmetic_unit_top import mau_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_t            out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [ResW-1:0] cfg_data_i
);

  logic [ResW-1:0] mod_q;
  logic            idle;

  // refuse a write while a request is offered, so no request sees two moduli
  assign cfg_ready_o = idle && !in_valid_i;

  // write the modulus
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= DefaultModulus;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mod_q <= cfg_data_i;
    end
  end

  mau_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mod_i       (mod_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .idle_o      (idle)
  );

endmodule

### rtl/mau_mulstep.sv
module mau_mulstep import mau_pkg::*; (
  input  logic [ResW-1:0] acc_i,
  input  logic [ResW-1:0] add_i,
  input  logic [ResW-1:0] mod_i,
  output logic [ResW-1:0] sum_o
);

  logic [ResW+1:0] sum;
  logic [ResW+1:0] mod1;
  logic [ResW+1:0] mod2;

  // double the accumulator, add the selected term, fold back below the modulus
  always_comb begin
    sum  = {1'b0, acc_i, 1'b0} + {2'b00, add_i};
    mod1 = {2'b00, mod_i};
    mod2 = {1'b0, mod_i, 1'b0};
    if (sum >= mod2) begin
      sum = sum - mod2;
    end else if (sum >= mod1) begin
      sum = sum - mod1;
    end
    sum_o = sum[ResW-1:0];
  end

endmodule

### rtl/mau_core.sv
module mau_core import mau_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ResW-1:0] mod_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_t            out_data_o,
  output logic            idle_o
);

  localparam int unsigned PadW = RawW - ResW;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [RawW-1:0] x_q, x_d;
  logic [ResW-1:0] y_q, y_d;
  logic [ResW-1:0] acc_q, acc_d;
  logic [6:0]      cnt_q, cnt_d;
  logic [ResW-1:0] base_q, base_d;
  logic [ExpW-1:0] exp_q, exp_d;
  logic [5:0]      ecnt_q, ecnt_d;
  logic            neg_q, neg_d;
  logic            div_q, div_d;
  logic [ResW-1:0] opa_q, opa_d;
  logic [ResW-1:0] res_q, res_d;
  logic            err_q, err_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  logic [ResW-1:0] step;
  logic [ResW-1:0] one_mod;
  logic [ResW-1:0] a, b;
  logic [ResW:0]   sum;
  logic [RawW-1:0] mag;
  logic            uses_b;
  logic            bad;
  logic            adv;

  mau_mulstep u_step (
    .acc_i (acc_q),
    .add_i (x_q[RawW-1] ? y_q : '0),
    .mod_i (mod_i),
    .sum_o (step)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign idle_o      = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;  phase_d = phase_q;  x_d = x_q;  y_d = y_q;
    acc_d = acc_q;  cnt_d = cnt_q;  base_d = base_q;  exp_d = exp_q;
    ecnt_d = ecnt_q;  neg_d = neg_q;  div_d = div_q;  opa_d = opa_q;
    res_d = res_q;  err_d = err_q;  out_valid_d = out_valid_q;  out_d = out_q;
    adv = 1'b0;

    a       = in_data_i.operand_a;
    b       = in_data_i.operand_b;
    one_mod = (mod_i == ResW'(1)) ? '0 : ResW'(1);
    uses_b  = (in_data_i.command == CMD_ADD) || (in_data_i.command == CMD_SUBTRACT) ||
              (in_data_i.command == CMD_MULTIPLY) || (in_data_i.command == CMD_DIVIDE);
    bad     = (mod_i == '0) || ((in_data_i.command != CMD_REDUCE) &&
              ((a >= mod_i) || (uses_b && (b >= mod_i))));
    sum     = {1'b0, a} + {1'b0, b};
    mag     = in_data_i.raw_value[RawW-1] ? (RawW'(0) - RawW'(in_data_i.raw_value))
                                          : RawW'(in_data_i.raw_value);

    // drop a delivered result
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          err_d   = 1'b0;
          res_d   = '0;
          state_d = ST_OUT;
          acc_d   = '0;
          cnt_d   = 7'(ResW);
          div_d   = 1'b0;
          if (bad) begin
            err_d = 1'b1;
          end else begin
            case (cmd_e'(in_data_i.command))
              CMD_REDUCE: begin
                neg_d = in_data_i.raw_value[RawW-1];
                x_d = mag;  y_d = one_mod;  cnt_d = 7'(RawW);
                phase_d = PH_RED;  state_d = ST_MUL;
              end
              CMD_NEGATE: res_d = (a == '0) ? '0 : mod_i - a;
              CMD_ADD: begin
                res_d = (sum >= {1'b0, mod_i}) ? ResW'(sum - {1'b0, mod_i}) : ResW'(sum);
              end
              CMD_SUBTRACT: begin
                res_d = (a >= b) ? a - b : ResW'({1'b0, a} + {1'b0, mod_i} - {1'b0, b});
              end
              CMD_MULTIPLY: begin
                x_d = {a, PadW'(0)};  y_d = b;
                phase_d = PH_MUL;  state_d = ST_MUL;
              end
              CMD_POWER: begin
                base_d = a;  exp_d = in_data_i.exponent;  ecnt_d = 6'(ExpW);
                x_d = {one_mod, PadW'(0)};  y_d = one_mod;
                phase_d = PH_SQ;  state_d = ST_MUL;
              end
              CMD_INVERSE: begin
                if (a != '0) begin
                  base_d = a;  exp_d = ExpW'(mod_i - ResW'(2));  ecnt_d = 6'(ExpW);
                  x_d = {one_mod, PadW'(0)};  y_d = one_mod;
                  phase_d = PH_SQ;  state_d = ST_MUL;
                end
              end
              default: begin
                if (b != '0) begin
                  base_d = b;  exp_d = ExpW'(mod_i - ResW'(2));  ecnt_d = 6'(ExpW);
                  div_d = 1'b1;  opa_d = a;
                  x_d = {one_mod, PadW'(0)};  y_d = one_mod;
                  phase_d = PH_SQ;  state_d = ST_MUL;
                end
              end
            endcase
          end
        end
      end

      // one multiplier bit per cycle, MSB first
      ST_MUL: begin
        acc_d = step;
        x_d   = x_q << 1;
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = ST_NEXT;
        end
      end

      // dispatch on the finished product
      ST_NEXT: begin
        case (phase_q)
          PH_RED: begin
            res_d   = (neg_q && (acc_q != '0)) ? mod_i - acc_q : acc_q;
            state_d = ST_OUT;
          end
          PH_MUL: begin
            res_d   = acc_q;
            state_d = ST_OUT;
          end
          PH_SQ: begin
            if (exp_q[ExpW-1]) begin
              x_d = {acc_q, PadW'(0)};  y_d = base_q;  acc_d = '0;
              cnt_d = 7'(ResW);  phase_d = PH_BM;  state_d = ST_MUL;
            end else begin
              adv = 1'b1;
            end
          end
          default: adv = 1'b1;
        endcase
        // advance to the next exponent bit
        if (adv) begin
          exp_d  = exp_q << 1;
          ecnt_d = ecnt_q - 6'd1;
          acc_d  = '0;
          cnt_d  = 7'(ResW);
          if (ecnt_q == 6'd1) begin
            if (div_q) begin
              x_d = {opa_q, PadW'(0)};  y_d = acc_q;  div_d = 1'b0;
              phase_d = PH_MUL;  state_d = ST_MUL;
            end else begin
              res_d = acc_q;  state_d = ST_OUT;
            end
          end else begin
            x_d = {acc_q, PadW'(0)};  y_d = acc_q;
            phase_d = PH_SQ;  state_d = ST_MUL;
          end
        end
      end

      // hold until the output register is free
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.result      = res_q;
          out_d.range_error = err_q;
          state_d           = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;  x_q <= x_d;  y_q <= y_d;  acc_q <= acc_d;
    cnt_q <= cnt_d;  base_q <= base_d;  exp_q <= exp_d;  ecnt_q <= ecnt_d;
    neg_q <= neg_d;  div_q <= div_d;  opa_q <= opa_d;  res_q <= res_d;
    err_q <= err_d;  out_q <= out_d;
  end

endmodule

### rtl/mau_checker.sv
module mau_checker import mau_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o,
  input logic cfg_ready_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an error result carries zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_error |-> out_data_o.result == '0)
    else $error("range error with nonzero result");

  // a taken request keeps the unit busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o)
    else $error("unit not busy after request");

  // configuration only while idle
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !in_stall_o)
    else $error("config ready while busy");

endmodule

bind modular_arithmetic_unit_top mau_checker u_mau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);
